>>> design/ffara_pkg.sv
// ---------------------------------------------------------------------------
// ffara_pkg
// Shared types and constants for the first-fit aligned range allocator.
// ---------------------------------------------------------------------------
package ffara_pkg;

  localparam int MAX_SLOTS   = 64;
  localparam int OFFSET_BITS = 32;
  localparam int IDX_BITS    = $clog2(MAX_SLOTS);
  localparam int CNT_BITS    = $clog2(MAX_SLOTS + 1);
  localparam int OWNER_BITS  = 16;

  typedef logic [OFFSET_BITS-1:0] off_t;
  typedef logic [OWNER_BITS-1:0]  owner_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_t;

  typedef struct packed {
    off_t   start;
    off_t   length;
    owner_t owner;
  } slot_t;

  // Shift command applied to the whole cell row at once.
  typedef enum logic [1:0] {
    SH_HOLD   = 2'd0,
    SH_INSERT = 2'd1,
    SH_REMOVE = 2'd2
  } shift_op_t;

  typedef struct packed {
    shift_op_t        op;
    logic [IDX_BITS-1:0] pos;
    slot_t            data;
  } shift_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_MOD,
    S_FIT,
    S_DONE
  } fsm_t;

endpackage

>>> design/ffara_cell.sv
// ---------------------------------------------------------------------------
// ffara_cell
// One table entry. Shifts toward higher or lower index on insert or remove.
// ---------------------------------------------------------------------------
module ffara_cell (
  input  logic                                clk,
  input  logic [ffara_pkg::IDX_BITS-1:0]      my_idx,
  input  ffara_pkg::shift_cmd_t               cmd,
  input  ffara_pkg::slot_t                    lower,
  input  ffara_pkg::slot_t                    upper,
  output ffara_pkg::slot_t                    slot
);

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      ffara_pkg::SH_INSERT: begin
        if (my_idx == cmd.pos) begin
          slot <= cmd.data;
        end else if (my_idx > cmd.pos) begin
          slot <= lower;
        end
      end
      ffara_pkg::SH_REMOVE: begin
        if (my_idx >= cmd.pos) begin
          slot <= upper;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> design/ffara_divider.sv
// ---------------------------------------------------------------------------
// ffara_divider
// Restoring remainder unit, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ffara_divider (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ffara_pkg::off_t   dividend,
  input  ffara_pkg::off_t   divisor,
  output logic              done,
  output ffara_pkg::off_t   remainder
);

  localparam int CB = $clog2(ffara_pkg::OFFSET_BITS + 1);

  ffara_pkg::off_t         num;
  ffara_pkg::off_t         den;
  logic [ffara_pkg::OFFSET_BITS:0] rem;
  logic [CB-1:0]           count;
  logic                    busy;
  logic [ffara_pkg::OFFSET_BITS:0] trial;

  assign trial     = {rem[ffara_pkg::OFFSET_BITS-1:0], num[ffara_pkg::OFFSET_BITS-1]};
  assign remainder = rem[ffara_pkg::OFFSET_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        num   <= dividend;
        den   <= divisor;
        rem   <= '0;
        count <= CB'(ffara_pkg::OFFSET_BITS);
      end else if (busy) begin
        num <= num << 1;
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
        end else begin
          rem <= trial;
        end
        count <= count - 1'b1;
        if (count == CB'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/first_fit_aligned_range_allocator_unit.sv
// ---------------------------------------------------------------------------
// first_fit_aligned_range_allocator_unit
// First-fit aligned sub-allocator over a pool, with a sorted slot table.
// ---------------------------------------------------------------------------
// Usage: a request transaction on req_valid/req_ready carries req_type,
// request_bytes, align_bytes and owner_tag. Each request yields exactly one
// response transaction on rsp_valid/rsp_ready with status, start_offset and
// live_count. The user must write the pool size through cfg_we/cfg_data
// only while idle; the block itself does not enforce this. The table is a
// row of cells that shift by one entry on insert or remove. An allocate
// visits each gap in order; each gap is read, then a bit-serial remainder
// of the gap start by the alignment is formed, then a fit check is made.
// A free scans one cell per cycle until it finds the owner or the end.
// The response register is loaded at the end and the next request is taken
// only after the response is accepted. A stalled receiver simply holds the
// block. Reset empties the table and sets the pool size to 65536; the
// stored entries themselves are not cleared.
// ---------------------------------------------------------------------------
module first_fit_aligned_range_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        req_type,
  input  logic [31:0] request_bytes,
  input  logic [31:0] align_bytes,
  input  logic [15:0] owner_tag,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [1:0]  status,
  output logic [31:0] start_offset,
  output logic [6:0]  live_count
);

  localparam int N  = ffara_pkg::MAX_SLOTS;
  localparam int IB = ffara_pkg::IDX_BITS;
  localparam int CB = ffara_pkg::CNT_BITS;

  ffara_pkg::fsm_t       state, state_next;
  ffara_pkg::off_t       pool;
  logic [CB-1:0]         used;
  logic [CB-1:0]         idx;
  logic                  kind;
  ffara_pkg::off_t       size;
  ffara_pkg::off_t       align;
  ffara_pkg::owner_t     owner;
  ffara_pkg::off_t       prev;
  ffara_pkg::off_t       gap_end;
  ffara_pkg::slot_t      cur;
  ffara_pkg::slot_t      slots [N];
  ffara_pkg::shift_cmd_t cmd;
  logic                  div_start;
  logic                  div_done;
  ffara_pkg::off_t       div_rem;
  ffara_pkg::off_t       pad;
  ffara_pkg::off_t       room;
  logic                  fits;
  logic                  at_end;
  ffara_pkg::slot_t      rd_slot;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      ffara_pkg::slot_t lo, hi;
      if (g == 0) begin : g_lo0
        assign lo = '0;
      end else begin : g_lo
        assign lo = slots[g-1];
      end
      if (g == N - 1) begin : g_hiN
        assign hi = '0;
      end else begin : g_hi
        assign hi = slots[g+1];
      end
      ffara_cell u_cell (
        .clk    (clk),
        .my_idx (IB'(g)),
        .cmd    (cmd),
        .lower  (lo),
        .upper  (hi),
        .slot   (slots[g])
      );
    end
  endgenerate

  ffara_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (prev),
    .divisor   (align),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign rd_slot = slots[idx[IB-1:0]];
  assign at_end  = (idx == used);
  assign pad     = (div_rem == '0) ? '0 : align - div_rem;
  assign room    = gap_end - prev;
  assign fits    = (gap_end >= prev) && (room >= pad) && (room - pad >= size);

  assign req_ready = (state == ffara_pkg::S_IDLE) && !rsp_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffara_pkg::S_IDLE;
      pool      <= 32'd65536;
      used      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        pool <= cfg_data;
      end
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (req_valid && req_ready) begin
        kind  <= req_type;
        size  <= request_bytes;
        align <= (align_bytes == '0) ? 32'd1 : align_bytes;
        owner <= owner_tag;
        prev  <= '0;
        idx   <= '0;
      end
      unique case (state)
        ffara_pkg::S_WALK: begin
          if (kind) begin
            if (!at_end && rd_slot.owner == owner) begin
              used         <= used - 1'b1;
              status       <= ffara_pkg::ST_OK;
              start_offset <= '0;
              live_count   <= 7'(used - 1'b1);
              rsp_valid    <= 1'b1;
            end else if (at_end) begin
              status       <= ffara_pkg::ST_NOT_FOUND;
              start_offset <= '0;
              live_count   <= 7'(used);
              rsp_valid    <= 1'b1;
            end else begin
              idx <= idx + 1'b1;
            end
          end else if (used == CB'(N)) begin
            status       <= ffara_pkg::ST_TABLE_FULL;
            start_offset <= '0;
            live_count   <= 7'(used);
            rsp_valid    <= 1'b1;
          end else begin
            cur     <= rd_slot;
            gap_end <= at_end ? pool : rd_slot.start;
          end
        end
        ffara_pkg::S_FIT: begin
          if (fits) begin
            used         <= used + 1'b1;
            status       <= ffara_pkg::ST_OK;
            start_offset <= prev + pad;
            live_count   <= 7'(used + 1'b1);
            rsp_valid    <= 1'b1;
          end else if (at_end) begin
            status       <= ffara_pkg::ST_NO_SPACE;
            start_offset <= '0;
            live_count   <= 7'(used);
            rsp_valid    <= 1'b1;
          end else begin
            prev <= cur.start + cur.length;
            idx  <= idx + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    cmd        = '{op: ffara_pkg::SH_HOLD, pos: idx[IB-1:0], data: '0};
    unique case (state)
      ffara_pkg::S_IDLE: begin
        if (req_valid && req_ready) begin
          state_next = ffara_pkg::S_WALK;
        end
      end
      ffara_pkg::S_WALK: begin
        if (kind) begin
          if (!at_end && rd_slot.owner == owner) begin
            cmd.op     = ffara_pkg::SH_REMOVE;
            state_next = ffara_pkg::S_IDLE;
          end else if (at_end) begin
            state_next = ffara_pkg::S_IDLE;
          end
        end else if (used == CB'(N)) begin
          state_next = ffara_pkg::S_IDLE;
        end else begin
          div_start  = 1'b1;
          state_next = ffara_pkg::S_MOD;
        end
      end
      ffara_pkg::S_MOD: begin
        if (div_done) begin
          state_next = ffara_pkg::S_FIT;
        end
      end
      ffara_pkg::S_FIT: begin
        if (fits) begin
          cmd.op     = ffara_pkg::SH_INSERT;
          cmd.data   = '{start: prev + pad, length: size, owner: owner};
          state_next = ffara_pkg::S_IDLE;
        end else if (at_end) begin
          state_next = ffara_pkg::S_IDLE;
        end else begin
          state_next = ffara_pkg::S_WALK;
        end
      end
      default: begin
        state_next = ffara_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    used <= CB'(N))
    else $error("live count exceeds table depth");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(start_offset))
    else $error("response changed while stalled");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ffara_pkg::S_IDLE |-> !req_ready)
    else $error("request accepted while busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ffara_pkg::ST_OK |-> start_offset == '0)
    else $error("nonzero offset on failed request");
`endif

endmodule

>>> test/first_fit_aligned_range_allocator_unit_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// first_fit_aligned_range_allocator_unit_test
// Self-checking bench for the first-fit aligned range allocator. A directed
// table covers extremes, zero length, zero alignment and frees of unknown
// owners; directed runs then shrink the pool and fill the table. Random
// allocate/free traffic follows, under three idling profiles, a long receiver
// stall and a drain pause. Every response is checked against a behavioral allocator model.
// ---------------------------------------------------------------------------
module first_fit_aligned_range_allocator_unit_test;

  localparam int     DRAIN_CYCLES = 3000;
  localparam logic   REQ_ALLOC    = 1'b0;
  localparam logic   REQ_FREE     = 1'b1;
  localparam logic   NO_CHECK     = 1'b0;
  localparam logic   CHECK_FIXED  = 1'b1;

  typedef struct {
    logic               kind;
    ffara_pkg::off_t    size;
    ffara_pkg::off_t    align;
    ffara_pkg::owner_t  owner;
    logic               fixed;
    ffara_pkg::status_t st;
    ffara_pkg::off_t    offset;
    int                 count;
  } dir_row_t;

  typedef struct {
    ffara_pkg::status_t st;
    ffara_pkg::off_t    offset;
    logic [6:0]         count;
  } grant_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_data;
  logic        req_valid;
  logic        req_ready;
  logic        req_type;
  logic [31:0] request_bytes;
  logic [31:0] align_bytes;
  logic [15:0] owner_tag;
  logic        rsp_valid;
  logic        rsp_ready;
  logic [1:0]  status;
  logic [31:0] start_offset;
  logic [6:0]  live_count;

  first_fit_aligned_range_allocator_unit u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
    .request_bytes(request_bytes), .align_bytes(align_bytes),
    .owner_tag(owner_tag), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .status(status), .start_offset(start_offset), .live_count(live_count)
  );

  // Allocation table mirror.
  logic [63:0]       pool_size;
  logic [63:0]       tbl_start [ffara_pkg::MAX_SLOTS];
  logic [63:0]       tbl_len [ffara_pkg::MAX_SLOTS];
  ffara_pkg::owner_t tbl_owner [ffara_pkg::MAX_SLOTS];
  int                tbl_used;

  grant_t      pending_grants[$];
  int          errors;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          stall_cycles;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic grant_t allocate_range(ffara_pkg::off_t size, ffara_pkg::off_t align_in,
                                            ffara_pkg::owner_t owner);
    grant_t      g;
    logic [63:0] prev;
    logic [63:0] align;
    logic [63:0] gap_end;
    logic [63:0] pad;
    logic [63:0] room;
    g.st = ffara_pkg::ST_NO_SPACE;
    g.offset = '0;
    prev = 0;
    align = (align_in == 0) ? 64'd1 : {32'd0, align_in};
    if (tbl_used >= ffara_pkg::MAX_SLOTS) begin
      g.st = ffara_pkg::ST_TABLE_FULL;
      g.count = tbl_used[6:0];
      return g;
    end
    for (int i = 0; i <= tbl_used; i++) begin
      gap_end = (i < tbl_used) ? tbl_start[i] : pool_size;
      pad = (prev % align == 0) ? 64'd0 : align - prev % align;
      if (gap_end >= prev) begin
        room = gap_end - prev;
        if (room >= pad && room - pad >= {32'd0, size}) begin
          for (int j = tbl_used; j > i; j--) begin
            tbl_start[j] = tbl_start[j-1];
            tbl_len[j] = tbl_len[j-1];
            tbl_owner[j] = tbl_owner[j-1];
          end
          tbl_start[i] = (prev + pad) & 64'hFFFF_FFFF;
          tbl_len[i] = {32'd0, size};
          tbl_owner[i] = owner;
          tbl_used++;
          g.st = ffara_pkg::ST_OK;
          g.offset = tbl_start[i][31:0];
          g.count = tbl_used[6:0];
          return g;
        end
      end
      if (i < tbl_used) prev = (tbl_start[i] + tbl_len[i]) & 64'hFFFF_FFFF;
    end
    g.count = tbl_used[6:0];
    return g;
  endfunction

  function automatic grant_t release_owner(ffara_pkg::owner_t owner);
    grant_t g;
    g.st = ffara_pkg::ST_NOT_FOUND;
    g.offset = '0;
    for (int i = 0; i < tbl_used; i++) begin
      if (tbl_owner[i] == owner) begin
        for (int j = i; j < tbl_used - 1; j++) begin
          tbl_start[j] = tbl_start[j+1];
          tbl_len[j] = tbl_len[j+1];
          tbl_owner[j] = tbl_owner[j+1];
        end
        tbl_used--;
        g.st = ffara_pkg::ST_OK;
        break;
      end
    end
    g.count = tbl_used[6:0];
    return g;
  endfunction

  task automatic send_request(logic kind, ffara_pkg::off_t size, ffara_pkg::off_t align,
                              ffara_pkg::owner_t owner, logic fixed,
                              ffara_pkg::status_t fst, ffara_pkg::off_t foff, int fcnt);
    grant_t g;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_type <= kind;
    request_bytes <= size;
    align_bytes <= align;
    owner_tag <= owner;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    g = (kind == REQ_ALLOC) ? allocate_range(size, align, owner) : release_owner(owner);
    if (fixed && (g.st != fst || g.offset != foff || g.count != fcnt[6:0])) begin
      $display("%0t directed row: expected %0d/%0h/%0d got %0d/%0h/%0d",
               $time, fst, foff, fcnt, g.st, g.offset, g.count);
      errors++;
    end
    pending_grants.push_back(g);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending_grants.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_pool(logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    pool_size = {32'd0, value};
  endtask

  // Mostly well-formed traffic: small sizes, power-of-two alignments, and
  // frees of owners drawn from a small pool so most frees hit.
  task automatic random_phase(int count);
    logic              kind;
    ffara_pkg::off_t   size;
    ffara_pkg::off_t   align;
    ffara_pkg::owner_t owner;
    int                r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      kind = (r < 45) ? REQ_FREE : REQ_ALLOC;
      owner = ($urandom_range(9) == 0) ? ffara_pkg::owner_t'($urandom)
                                       : ffara_pkg::owner_t'($urandom_range(31));
      if ($urandom_range(19) == 0) size = $urandom;
      else size = $urandom_range(4096);
      case ($urandom_range(5))
        0: align = $urandom;
        1: align = 0;
        2: align = $urandom_range(100);
        default: align = 32'd1 << $urandom_range(12);
      endcase
      send_request(kind, size, align, owner, NO_CHECK, ffara_pkg::ST_OK, '0, 0);
    end
  endtask

  always @(posedge clk) begin
    grant_t g;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_grants.size() == 0) begin
        $display("%0t unexpected response: expected none got %0d/%0h/%0d",
                 $time, status, start_offset, live_count);
        errors++;
      end else begin
        g = pending_grants.pop_front();
        if (status != g.st) begin
          $display("%0t status: expected %0d got %0d", $time, g.st, status);
          errors++;
        end
        if (start_offset != g.offset) begin
          $display("%0t start_offset: expected %0h got %0h", $time, g.offset, start_offset);
          errors++;
        end
        if (live_count != g.count) begin
          $display("%0t live_count: expected %0d got %0d", $time, g.count, live_count);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall_cycles > 0) begin
      stall_cycles <= stall_cycles - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #400ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    dir_row_t rows[$];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    req_valid = 1'b0;
    req_type = REQ_ALLOC;
    request_bytes = '0;
    align_bytes = 32'd1;
    owner_tag = '0;
    rsp_ready = 1'b0;
    errors = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_cycles = 0;
    pool_size = 64'd65536;
    tbl_used = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    rows = '{
      '{REQ_FREE,  32'd0,          32'd1,          16'h0000, CHECK_FIXED,
        ffara_pkg::ST_NOT_FOUND, 0, 0},
      '{REQ_ALLOC, 32'd65537,      32'd1,          16'h0001, CHECK_FIXED,
        ffara_pkg::ST_NO_SPACE, 0, 0},
      '{REQ_ALLOC, 32'd65536,      32'd1,          16'hFFFF, CHECK_FIXED,
        ffara_pkg::ST_OK, 0, 1},
      '{REQ_ALLOC, 32'd0,          32'd0,          16'h0002, CHECK_FIXED,
        ffara_pkg::ST_OK, 0, 2},
      '{REQ_ALLOC, 32'd1,          32'd1,          16'h0003, CHECK_FIXED,
        ffara_pkg::ST_NO_SPACE, 0, 2},
      '{REQ_FREE,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  16'hFFFF, CHECK_FIXED,
        ffara_pkg::ST_OK, 0, 1},
      '{REQ_ALLOC, 32'd100,        32'd0,          16'h0004, NO_CHECK, ffara_pkg::ST_OK, 0, 0},
      '{REQ_ALLOC, 32'd10,         32'd4096,       16'h0005, NO_CHECK, ffara_pkg::ST_OK, 0, 0},
      '{REQ_ALLOC, 32'd7,          32'hFFFF_FFFF,  16'h0006, NO_CHECK, ffara_pkg::ST_OK, 0, 0},
      '{REQ_ALLOC, 32'hFFFF_FFFF,  32'd1,          16'h0007, NO_CHECK, ffara_pkg::ST_OK, 0, 0},
      '{REQ_ALLOC, 32'd0,          32'h8000_0000,  16'h0008, NO_CHECK, ffara_pkg::ST_OK, 0, 0},
      '{REQ_FREE,  32'd0,          32'd1,          16'h0005, NO_CHECK, ffara_pkg::ST_OK, 0, 0},
      '{REQ_ALLOC, 32'd33,         32'd3,          16'h0009, NO_CHECK, ffara_pkg::ST_OK, 0, 0},
      '{REQ_FREE,  32'd0,          32'd1,          16'h1234, NO_CHECK, ffara_pkg::ST_OK, 0, 0}
    };
    foreach (rows[k])
      send_request(rows[k].kind, rows[k].size, rows[k].align, rows[k].owner,
                   rows[k].fixed, rows[k].st, rows[k].offset, rows[k].count);
    wait_drained();

    // Shrink the pool below live entries, then fill the table with
    // zero-length ranges until it reports full.
    write_pool(32'd50);
    send_request(REQ_ALLOC, 32'd1, 32'd1, 16'h0010, NO_CHECK, ffara_pkg::ST_OK, '0, 0);
    wait_drained();
    write_pool(32'hFFFF_FFFF);
    for (int k = 0; k < ffara_pkg::MAX_SLOTS + 2; k++)
      send_request(REQ_ALLOC, 32'd0, 32'd1, ffara_pkg::owner_t'(16'h0100 + k), NO_CHECK,
                   ffara_pkg::ST_OK, '0, 0);
    for (int k = 0; k < ffara_pkg::MAX_SLOTS; k++)
      send_request(REQ_FREE, 32'd0, 32'd1, ffara_pkg::owner_t'(16'h0100 + k), NO_CHECK,
                   ffara_pkg::ST_OK, '0, 0);
    for (int k = 0; k < 12; k++)
      send_request(REQ_FREE, 32'd0, 32'd1, ffara_pkg::owner_t'(k), NO_CHECK,
                   ffara_pkg::ST_OK, '0, 0);
    wait_drained();

    write_pool(32'd1);
    send_idle_pct = 12;
    recv_idle_pct = 54;
    random_phase(200);
    wait_drained();

    write_pool(32'd65536);
    stall_cycles = 2000;
    random_phase(400);
    send_idle_pct = 54;
    recv_idle_pct = 12;
    random_phase(400);
    wait_drained();

    write_pool(32'd20000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(400);
    wait_drained();

    write_pool($urandom);
    random_phase(400);
    wait_drained();

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/ffara_pkg.sv
design/ffara_cell.sv
design/ffara_divider.sv
design/first_fit_aligned_range_allocator_unit.sv
test/first_fit_aligned_range_allocator_unit_test.sv
